// ===== hdl/sphere_capsule_distance_defines.svh =====
// Assertion macros shared by the sphere to capsule distance design.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SPHERE_CAPSULE_DISTANCE_DEFINES_SVH
`define SPHERE_CAPSULE_DISTANCE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sphere capsule distance assertion failed");
`define SCD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphere capsule distance assertion failed");
`else
`define SCD_ASSERT(name, prop)
`define SCD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/scd_pkg.sv =====
// Package of the sphere to capsule distance pipeline: types, constants, helpers.
// No dependencies.
package scd_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [30:0] radius_t;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_END,
    MODE_FRAC
  } mode_e;

  localparam int unsigned PipeDepth = 109;

  function automatic logic [31:0] sat32(logic signed [35:0] x);
    logic [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/scd_in_if.sv =====
// Input channel of the sphere to capsule distance block: one query per item.
// Depends on scd_pkg.
interface scd_in_if;
  import scd_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  sphere_x;
  coord_t  sphere_y;
  coord_t  sphere_z;
  radius_t sphere_radius;
  coord_t  seg_start_x;
  coord_t  seg_start_y;
  coord_t  seg_start_z;
  coord_t  seg_end_x;
  coord_t  seg_end_y;
  coord_t  seg_end_z;
  radius_t capsule_radius;

  modport source (output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
                  seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
                  seg_end_z, capsule_radius, input ready);
  modport sink (input valid, sphere_x, sphere_y, sphere_z, sphere_radius,
                seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
                seg_end_z, capsule_radius, output ready);
endinterface

// ===== hdl/scd_out_if.sv =====
// Output channel of the sphere to capsule distance block: one result per item.
// Depends on scd_pkg.
interface scd_out_if;
  import scd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t gap;
  coord_t gap_vec_x;
  coord_t gap_vec_y;
  coord_t gap_vec_z;
  coord_t near_sphere_x;
  coord_t near_sphere_y;
  coord_t near_sphere_z;
  coord_t near_capsule_x;
  coord_t near_capsule_y;
  coord_t near_capsule_z;

  modport source (output valid, gap, gap_vec_x, gap_vec_y, gap_vec_z, near_sphere_x,
                  near_sphere_y, near_sphere_z, near_capsule_x, near_capsule_y,
                  near_capsule_z, input ready);
  modport sink (input valid, gap, gap_vec_x, gap_vec_y, gap_vec_z, near_sphere_x,
                near_sphere_y, near_sphere_z, near_capsule_x, near_capsule_y,
                near_capsule_z, output ready);
endinterface

// ===== hdl/sphere_capsule_distance.sv =====
// One item per cycle while no waiting result is held back by the output.
// The pipeline holds 109 stages: a 32-stage divider for the segment parameter,
// a 34-stage square root and a 31-stage divider for the unit direction.
// A waiting result that is not taken holds the whole pipeline in place.
// Reset clears all valid bits; the data registers are not reset.
// Top level of the sphere to capsule distance block.
// Depends on scd_pkg, scd_in_if, scd_out_if and the defines header.
`include "sphere_capsule_distance_defines.svh"
module sphere_capsule_distance (
  input  logic clk_i,
  input  logic rst_ni,
  scd_in_if.sink    in_i,
  scd_out_if.source out_o
);
  import scd_pkg::*;

  localparam int unsigned DvFirst = 3;
  localparam int unsigned SqLast  = 75;
  localparam int unsigned UdLast  = 106;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][32:0] vec33_t;

  typedef struct packed {
    vec32_t c; vec32_t a; vec33_t d; vec33_t w; radius_t rs; radius_t rc;
  } s1_t;
  typedef struct packed {
    vec32_t c; vec32_t a; vec33_t d; logic [2:0][65:0] dw; logic [2:0][65:0] dd;
    radius_t rs; radius_t rc;
  } s2_t;
  typedef struct packed {
    vec32_t c; vec32_t a; vec33_t d; logic [67:0] proj; logic [67:0] len;
    radius_t rs; radius_t rc;
  } s3_t;
  typedef struct packed {
    vec32_t c; vec32_t a; vec33_t d; mode_e mode; logic [67:0] num; logic [67:0] len;
    logic [31:0] s; radius_t rs; radius_t rc;
  } dv_t;
  typedef struct packed {
    vec32_t c; vec32_t a; vec33_t d; mode_e mode; logic [2:0][64:0] m;
    radius_t rs; radius_t rc;
  } s4_t;
  typedef struct packed {
    vec32_t c; vec32_t p; radius_t rs; radius_t rc;
  } s5_t;
  typedef struct packed {
    vec32_t c; vec32_t p; vec33_t v; radius_t rs; radius_t rc;
  } s6_t;
  typedef struct packed {
    vec32_t c; vec32_t p; logic [2:0] vneg; vec33_t vmag; logic [2:0][65:0] vsq;
    radius_t rs; radius_t rc;
  } s7_t;
  typedef struct packed {
    vec32_t c; vec32_t p; logic [2:0] vneg; vec33_t vmag; logic [67:0] n;
    radius_t rs; radius_t rc;
  } s8_t;
  typedef struct packed {
    vec32_t c; vec32_t p; logic [2:0] vneg; vec33_t vmag; logic [67:0] n;
    logic [36:0] rem; logic [33:0] root; radius_t rs; radius_t rc;
  } sq_t;
  typedef struct packed {
    vec32_t c; vec32_t p; logic [2:0] vneg; logic [33:0] norm; logic [31:0] gap;
    logic [2:0][34:0] rem; logic [2:0][30:0] q; radius_t rs; radius_t rc;
  } ud_t;
  typedef struct packed {
    vec32_t c; vec32_t p; logic [2:0] vneg; logic gneg;
    logic [31:0] gap; logic [2:0][62:0] mg; logic [2:0][61:0] ms; logic [2:0][61:0] mc;
  } s9_t;
  typedef struct packed {
    logic [31:0] gap; vec32_t gv; vec32_t ns; vec32_t nc;
  } s10_t;

  logic                 en;
  logic [PipeDepth-1:0] vld_q;
  vec32_t               in_c, in_a, in_e;

  s1_t  s1_q;
  s2_t  s2_q;
  s3_t  s3_q;
  dv_t  dv_q [0:32];
  s4_t  s4_q;
  s5_t  s5_q;
  s6_t  s6_q;
  s7_t  s7_q;
  s8_t  s8_q;
  sq_t  sq_q [0:34];
  ud_t  ud_q [0:30];
  s9_t  s9_q;
  s10_t s10_q;

  function automatic dv_t div_step(dv_t x);
    logic [68:0] sh;
    dv_t         y;
    y  = x;
    sh = {x.num, 1'b0};
    if (sh >= {1'b0, x.len}) begin
      y.num = 68'(sh - {1'b0, x.len});
      y.s   = {x.s[30:0], 1'b1};
    end else begin
      y.num = sh[67:0];
      y.s   = {x.s[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic sq_t sqrt_step(sq_t x);
    logic [36:0] rem_sh;
    logic [36:0] trial;
    sq_t         y;
    y      = x;
    rem_sh = {x.rem[34:0], x.n[67:66]};
    trial  = {1'b0, x.root, 2'b01};
    y.n    = {x.n[65:0], 2'b00};
    if (rem_sh >= trial) begin
      y.rem  = rem_sh - trial;
      y.root = {x.root[32:0], 1'b1};
    end else begin
      y.rem  = rem_sh;
      y.root = {x.root[32:0], 1'b0};
    end
    return y;
  endfunction

  function automatic ud_t unit_step(ud_t x, logic first);
    logic [34:0] sh;
    ud_t         y;
    y = x;
    for (int i = 0; i < 3; i++) begin
      sh = first ? x.rem[i] : {x.rem[i][33:0], 1'b0};
      if (sh >= {1'b0, x.norm}) begin
        y.rem[i] = sh - {1'b0, x.norm};
        y.q[i]   = {x.q[i][29:0], 1'b1};
      end else begin
        y.rem[i] = sh;
        y.q[i]   = {x.q[i][29:0], 1'b0};
      end
    end
    return y;
  endfunction

  assign en          = !vld_q[PipeDepth-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[PipeDepth-1];

  assign in_c = {in_i.sphere_z, in_i.sphere_y, in_i.sphere_x};
  assign in_a = {in_i.seg_start_z, in_i.seg_start_y, in_i.seg_start_x};
  assign in_e = {in_i.seg_end_z, in_i.seg_end_y, in_i.seg_end_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Segment direction and offset of the sphere centre.
      s1_q.c  <= in_c;
      s1_q.a  <= in_a;
      s1_q.rs <= in_i.sphere_radius;
      s1_q.rc <= in_i.capsule_radius;
      for (int i = 0; i < 3; i++) begin
        s1_q.d[i] <= {in_e[i][31], in_e[i]} - {in_a[i][31], in_a[i]};
        s1_q.w[i] <= {in_c[i][31], in_c[i]} - {in_a[i][31], in_a[i]};
      end

      s2_q.c  <= s1_q.c;
      s2_q.a  <= s1_q.a;
      s2_q.d  <= s1_q.d;
      s2_q.rs <= s1_q.rs;
      s2_q.rc <= s1_q.rc;
      for (int i = 0; i < 3; i++) begin
        s2_q.dw[i] <= $signed(s1_q.d[i]) * $signed(s1_q.w[i]);
        s2_q.dd[i] <= $signed(s1_q.d[i]) * $signed(s1_q.d[i]);
      end

      s3_q.c    <= s2_q.c;
      s3_q.a    <= s2_q.a;
      s3_q.d    <= s2_q.d;
      s3_q.rs   <= s2_q.rs;
      s3_q.rc   <= s2_q.rc;
      s3_q.proj <= 68'($signed(s2_q.dw[0])) + 68'($signed(s2_q.dw[1]))
                 + 68'($signed(s2_q.dw[2]));
      s3_q.len  <= 68'(s2_q.dd[0]) + 68'(s2_q.dd[1]) + 68'(s2_q.dd[2]);

      // Clamp decision; the fraction is divided out one bit per stage.
      dv_q[0].c   <= s3_q.c;
      dv_q[0].a   <= s3_q.a;
      dv_q[0].d   <= s3_q.d;
      dv_q[0].rs  <= s3_q.rs;
      dv_q[0].rc  <= s3_q.rc;
      dv_q[0].num <= s3_q.proj;
      dv_q[0].len <= s3_q.len;
      dv_q[0].s   <= '0;
      if ($signed(s3_q.proj) <= 68'sd0) begin
        dv_q[0].mode <= MODE_START;
      end else if (s3_q.proj >= s3_q.len) begin
        dv_q[0].mode <= MODE_END;
      end else begin
        dv_q[0].mode <= MODE_FRAC;
      end
      for (int k = 0; k < 32; k++) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end

      s4_q.c    <= dv_q[32].c;
      s4_q.a    <= dv_q[32].a;
      s4_q.d    <= dv_q[32].d;
      s4_q.mode <= dv_q[32].mode;
      s4_q.rs   <= dv_q[32].rs;
      s4_q.rc   <= dv_q[32].rc;
      for (int i = 0; i < 3; i++) begin
        s4_q.m[i] <= dv_q[32].s * (dv_q[32].d[i][32] ? 33'(-dv_q[32].d[i]) : dv_q[32].d[i]);
      end

      s5_q.c  <= s4_q.c;
      s5_q.rs <= s4_q.rs;
      s5_q.rc <= s4_q.rc;
      for (int i = 0; i < 3; i++) begin
        unique case (s4_q.mode)
          MODE_START: s5_q.p[i] <= s4_q.a[i];
          MODE_END:   s5_q.p[i] <= 32'({s4_q.a[i][31], s4_q.a[i]} + s4_q.d[i]);
          MODE_FRAC: begin
            if (s4_q.d[i][32]) begin
              s5_q.p[i] <= 32'({s4_q.a[i][31], s4_q.a[i]} - s4_q.m[i][64:32]);
            end else begin
              s5_q.p[i] <= 32'({s4_q.a[i][31], s4_q.a[i]} + s4_q.m[i][64:32]);
            end
          end
          default:    s5_q.p[i] <= s4_q.a[i];
        endcase
      end

      s6_q.c  <= s5_q.c;
      s6_q.p  <= s5_q.p;
      s6_q.rs <= s5_q.rs;
      s6_q.rc <= s5_q.rc;
      for (int i = 0; i < 3; i++) begin
        s6_q.v[i] <= {s5_q.p[i][31], s5_q.p[i]} - {s5_q.c[i][31], s5_q.c[i]};
      end

      s7_q.c  <= s6_q.c;
      s7_q.p  <= s6_q.p;
      s7_q.rs <= s6_q.rs;
      s7_q.rc <= s6_q.rc;
      for (int i = 0; i < 3; i++) begin
        s7_q.vneg[i] <= s6_q.v[i][32];
        s7_q.vmag[i] <= s6_q.v[i][32] ? 33'(-s6_q.v[i]) : s6_q.v[i];
        s7_q.vsq[i]  <= $signed(s6_q.v[i]) * $signed(s6_q.v[i]);
      end

      s8_q.c    <= s7_q.c;
      s8_q.p    <= s7_q.p;
      s8_q.vneg <= s7_q.vneg;
      s8_q.vmag <= s7_q.vmag;
      s8_q.rs   <= s7_q.rs;
      s8_q.rc   <= s7_q.rc;
      s8_q.n    <= 68'(s7_q.vsq[0]) + 68'(s7_q.vsq[1]) + 68'(s7_q.vsq[2]);

      // Square root, two radicand bits per stage.
      sq_q[0].c    <= s8_q.c;
      sq_q[0].p    <= s8_q.p;
      sq_q[0].vneg <= s8_q.vneg;
      sq_q[0].vmag <= s8_q.vmag;
      sq_q[0].n    <= s8_q.n;
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].rs   <= s8_q.rs;
      sq_q[0].rc   <= s8_q.rc;
      for (int j = 0; j < 34; j++) begin
        sq_q[j+1] <= sqrt_step(sq_q[j]);
      end

      // Unit direction, one quotient bit per stage in each lane.
      ud_q[0] <= unit_step('{c: sq_q[34].c, p: sq_q[34].p, vneg: sq_q[34].vneg,
                             norm: sq_q[34].root,
                             gap: sat32($signed({2'b00, sq_q[34].root})
                                        - $signed({5'b0, sq_q[34].rs})
                                        - $signed({5'b0, sq_q[34].rc})),
                             rem: {{2'b0, sq_q[34].vmag[2]}, {2'b0, sq_q[34].vmag[1]},
                                   {2'b0, sq_q[34].vmag[0]}},
                             q: '0, rs: sq_q[34].rs, rc: sq_q[34].rc}, 1'b1);
      for (int k = 0; k < 30; k++) begin
        ud_q[k+1] <= unit_step(ud_q[k], 1'b0);
      end

      s9_q.c    <= ud_q[30].c;
      s9_q.p    <= ud_q[30].p;
      s9_q.vneg <= ud_q[30].vneg;
      s9_q.gap  <= ud_q[30].gap;
      s9_q.gneg <= ud_q[30].gap[31];
      for (int i = 0; i < 3; i++) begin
        if (ud_q[30].norm == '0) begin
          s9_q.mg[i] <= '0;
          s9_q.ms[i] <= '0;
          s9_q.mc[i] <= '0;
        end else begin
          s9_q.mg[i] <= (ud_q[30].gap[31] ? 32'(-ud_q[30].gap) : ud_q[30].gap)
                        * ud_q[30].q[i];
          s9_q.ms[i] <= ud_q[30].rs * ud_q[30].q[i];
          s9_q.mc[i] <= ud_q[30].rc * ud_q[30].q[i];
        end
      end

      s10_q.gap <= s9_q.gap;
      for (int i = 0; i < 3; i++) begin
        if (s9_q.gneg ^ s9_q.vneg[i]) begin
          s10_q.gv[i] <= 32'(-{1'b0, s9_q.mg[i][62:30]});
        end else begin
          s10_q.gv[i] <= s9_q.mg[i][61:30];
        end
        if (s9_q.vneg[i]) begin
          s10_q.ns[i] <= sat32(36'($signed(s9_q.c[i])) - $signed({4'b0, s9_q.ms[i][61:30]}));
          s10_q.nc[i] <= sat32(36'($signed(s9_q.p[i])) + $signed({4'b0, s9_q.mc[i][61:30]}));
        end else begin
          s10_q.ns[i] <= sat32(36'($signed(s9_q.c[i])) + $signed({4'b0, s9_q.ms[i][61:30]}));
          s10_q.nc[i] <= sat32(36'($signed(s9_q.p[i])) - $signed({4'b0, s9_q.mc[i][61:30]}));
        end
      end
    end
  end

  assign out_o.gap            = s10_q.gap;
  assign out_o.gap_vec_x      = s10_q.gv[0];
  assign out_o.gap_vec_y      = s10_q.gv[1];
  assign out_o.gap_vec_z      = s10_q.gv[2];
  assign out_o.near_sphere_x  = s10_q.ns[0];
  assign out_o.near_sphere_y  = s10_q.ns[1];
  assign out_o.near_sphere_z  = s10_q.ns[2];
  assign out_o.near_capsule_x = s10_q.nc[0];
  assign out_o.near_capsule_y = s10_q.nc[1];
  assign out_o.near_capsule_z = s10_q.nc[2];

  `SCD_ASSERT_NEXT(a_stall_holds_valids, !en, $stable(vld_q))
  `SCD_ASSERT(a_frac_below_len, vld_q[DvFirst] && dv_q[0].mode == MODE_FRAC |-> dv_q[0].num < dv_q[0].len)
  `SCD_ASSERT(a_sqrt_rem_bound, vld_q[SqLast] |-> sq_q[34].rem <= 37'(sq_q[34].root) * 37'd2)
  `SCD_ASSERT(a_unit_rem_bound, vld_q[UdLast] && ud_q[30].norm != '0 |-> ud_q[30].rem[0] < 35'(ud_q[30].norm) && ud_q[30].rem[1] < 35'(ud_q[30].norm) && ud_q[30].rem[2] < 35'(ud_q[30].norm))

endmodule
